/* rtl/spis_pkg.sv */
`default_nettype none

package spis_pkg;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int OP_W = DATA_W + 1;
   localparam int PROD_W = 2 * OP_W;
   localparam int RND_W = PROD_W + 1;
   localparam int SUM_W = DATA_W + 2;
   localparam int GATE_W = FRAC_W + 1;

   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam int PERIOD_W = 17;
   localparam int INV_PERIOD_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_PERIOD = CSR_IDX_W'(1);

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1311);
   localparam logic [INV_PERIOD_W-1:0] INV_PERIOD_RESET = INV_PERIOD_W'(3276800);

   localparam longint ZoneHi = ((longint'(5) << FRAC_W) + 50) / 100;
   localparam longint ZoneLo = ((longint'(1) << FRAC_W) + 50) / 100;
   localparam int GateNumW = $clog2(ZoneLo * (longint'(1) << FRAC_W) + 1);
   localparam int ZoneLoW = $clog2(ZoneLo + 1);
   localparam int RECIP_SHIFT = GateNumW + ZoneLoW;
   localparam longint Recip = ((longint'(1) << RECIP_SHIFT) + ZoneLo - 1) / ZoneLo;

   localparam logic [OP_W-1:0] ONE_Q = OP_W'(1) << FRAC_W;
   localparam logic [OP_W-1:0] HALF_Q = OP_W'(1) << (FRAC_W - 1);
   localparam logic [OP_W-1:0] ZONE_HI_Q = OP_W'(ZoneHi);
   localparam logic [OP_W-1:0] ZONE_LO_Q = OP_W'(ZoneLo);
   localparam logic [OP_W-1:0] ZONE_SPAN_Q = OP_W'(ZoneHi - ZoneLo);
   localparam logic [OP_W-1:0] RECIP_Q = OP_W'(Recip);
   localparam logic [GATE_W-1:0] GATE_ONE = GATE_W'(1) << FRAC_W;

   localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << (FRAC_W - 1);
   localparam logic [DATA_W-1:0] W_MAX_U = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam logic [DATA_W-1:0] W_MIN_U = {1'b1, {(DATA_W - 1){1'b0}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] err_long;
      logic signed [DATA_W-1:0] ref_speed;
      logic signed [DATA_W-1:0] gain_p;
      logic signed [DATA_W-1:0] gain_i;
      logic signed [DATA_W-1:0] gain_d;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] speed_cmd;
      logic saturated;
   } rsp_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [INV_PERIOD_W-1:0] inverse_period;
   } cfg_type;

   typedef struct packed {
      logic signed [OP_W-1:0] a;
      logic signed [OP_W-1:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic [PROD_W-1:0] raw;
      logic signed [DATA_W-1:0] qval;
      logic clip;
   } mul_res_type;

   typedef struct packed {
      logic clip;
      logic signed [DATA_W-1:0] value;
   } clamp_type;

   function automatic logic [DATA_W-1:0] magnitude(input logic signed [DATA_W-1:0] v);
      logic [DATA_W-1:0] u;
      u = unsigned'(v);
      return v[DATA_W-1] ? (~u + 1'b1) : u;
   endfunction

   function automatic clamp_type clamp_w(input logic signed [SUM_W-1:0] v);
      clamp_type r;
      logic fits;
      fits = (v[SUM_W-1:DATA_W-1] == '0) || (v[SUM_W-1:DATA_W-1] == '1);
      r.clip = !fits;
      if (fits) begin
         r.value = v[DATA_W-1:0];
      end else if (v[SUM_W-1]) begin
         r.value = W_MIN_U;
      end else begin
         r.value = W_MAX_U;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/spis_csr.sv */
`default_nettype none

module spis_csr
   import spis_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_PERIOD) begin
            cfg_in.period = csr_data[PERIOD_W-1:0];
         end else if (csr_index == CSR_INVERSE_PERIOD) begin
            cfg_in.inverse_period = csr_data[INV_PERIOD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period <= PERIOD_RESET;
         cfg_ff.inverse_period <= INV_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/spis_mul.sv */
`default_nettype none

module spis_mul
   import spis_pkg::*;
(
   input  wire logic  clock,
   input  wire mul_cmd_type cmd,
   output mul_res_type res
);

   logic [OP_W-1:0] mag_a, mag_b;
   logic [PROD_W-1:0] prod_in, prod_ff;
   logic neg_in, neg_ff;
   logic [RND_W-1:0] rounded, shifted, limit, chosen;
   logic [DATA_W-1:0] mag_q;

   always_comb begin
      mag_a = cmd.a[OP_W-1] ? (~unsigned'(cmd.a) + 1'b1) : unsigned'(cmd.a);
      mag_b = cmd.b[OP_W-1] ? (~unsigned'(cmd.b) + 1'b1) : unsigned'(cmd.b);
      prod_in = PROD_W'(mag_a) * PROD_W'(mag_b);
      neg_in = cmd.a[OP_W-1] ^ cmd.b[OP_W-1];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff <= neg_in;
   end

   // Round half away from zero on the magnitude, then clip to the signed range.
   always_comb begin
      rounded = {1'b0, prod_ff} + ROUND_HALF;
      shifted = rounded >> FRAC_W;
      limit = RND_W'(W_MAX_U) + RND_W'(neg_ff);
      res.clip = shifted > limit;
      chosen = res.clip ? limit : shifted;
      mag_q = chosen[DATA_W-1:0];
      res.qval = neg_ff ? (~mag_q + 1'b1) : mag_q;
      res.raw = prod_ff;
   end

endmodule

`default_nettype wire

/* rtl/speed_pid_integral_separation_top.sv */
`default_nettype none

// Speed loop PID with integral separation and reference speed feedforward, signed Q16.16.
// Each request runs nine passes through one shared 33 by 33 bit multiplier, each pass an
// issue state and a wait state, followed by a final state that forms and saturates the
// command; that state holds while a previous result still waits to be taken. req_stall
// stays high from acceptance until the block is idle again. The result sits in an output
// register, so a new request is taken while it waits. The period and inverse_period
// registers reset to 0.02 s and 50 and may be written at any time the block is idle.
module speed_pid_integral_separation_top
   import spis_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_ZONE   = 5'd1;
   localparam logic [4:0] ST_ZONE_W = 5'd2;
   localparam logic [4:0] ST_GATE   = 5'd3;
   localparam logic [4:0] ST_GATE_W = 5'd4;
   localparam logic [4:0] ST_KIE    = 5'd5;
   localparam logic [4:0] ST_KIE_W  = 5'd6;
   localparam logic [4:0] ST_TERR   = 5'd7;
   localparam logic [4:0] ST_TERR_W = 5'd8;
   localparam logic [4:0] ST_ACC    = 5'd9;
   localparam logic [4:0] ST_ACC_W  = 5'd10;
   localparam logic [4:0] ST_INT    = 5'd11;
   localparam logic [4:0] ST_INT_W  = 5'd12;
   localparam logic [4:0] ST_P      = 5'd13;
   localparam logic [4:0] ST_P_W    = 5'd14;
   localparam logic [4:0] ST_D1     = 5'd15;
   localparam logic [4:0] ST_D1_W   = 5'd16;
   localparam logic [4:0] ST_D2     = 5'd17;
   localparam logic [4:0] ST_D2_W   = 5'd18;
   localparam logic [4:0] ST_DONE   = 5'd19;

   cfg_type cfg;
   mul_cmd_type mul_cmd;
   mul_res_type mul_res;

   logic [4:0] state_ff, state_in;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [OP_W-1:0] zone_ff, zone_in;
   logic [GATE_W-1:0] gate_ff, gate_in;
   logic signed [DATA_W-1:0] tmp_ff, tmp_in;
   logic signed [DATA_W-1:0] p_ff, p_in;
   logic signed [DATA_W-1:0] d_ff, d_in;
   logic signed [DATA_W-1:0] int_ff, int_in;
   logic signed [DATA_W-1:0] prev_ff, prev_in;
   logic started_ff, started_in;
   logic sat_ff, sat_in;

   logic [OP_W-1:0] abs_v, abs_e, gap, gap_shift;
   logic signed [OP_W-1:0] diff;
   logic signed [SUM_W-1:0] int_sum, cmd_sum;
   clamp_type int_clamp, cmd_clamp;
   logic slot_free;

   spis_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   spis_mul u_mul (
      .clock (clock),
      .cmd   (mul_cmd),
      .res   (mul_res)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      abs_v = OP_W'(magnitude(req_ff.ref_speed));
      abs_e = OP_W'(magnitude(req_ff.err_long));
      gap = abs_e - zone_ff;
      gap_shift = gap << FRAC_W;
      diff = started_ff ? (OP_W'(req_ff.err_long) - OP_W'(prev_ff)) : '0;
      int_sum = SUM_W'(int_ff) + SUM_W'(mul_res.qval);
      int_clamp = clamp_w(int_sum);
      cmd_sum = SUM_W'(p_ff) + SUM_W'(int_ff) + SUM_W'(d_ff) + SUM_W'(req_ff.ref_speed);
      cmd_clamp = clamp_w(cmd_sum);
   end

   always_comb begin
      mul_cmd.a = '0;
      mul_cmd.b = '0;
      unique case (state_ff)
         ST_ZONE: begin
            mul_cmd.a = signed'(OP_W'(abs_v[FRAC_W-2:0]));
            mul_cmd.b = signed'(ZONE_SPAN_Q);
         end
         ST_GATE: begin
            mul_cmd.a = signed'(gap_shift);
            mul_cmd.b = signed'(RECIP_Q);
         end
         ST_KIE: begin
            mul_cmd.a = OP_W'(req_ff.gain_i);
            mul_cmd.b = signed'(OP_W'(gate_ff));
         end
         ST_TERR: begin
            mul_cmd.a = OP_W'(tmp_ff);
            mul_cmd.b = OP_W'(req_ff.err_long);
         end
         ST_ACC: begin
            mul_cmd.a = OP_W'(tmp_ff);
            mul_cmd.b = signed'(OP_W'(cfg.period));
         end
         ST_INT: begin
            mul_cmd.a = OP_W'(tmp_ff);
            mul_cmd.b = signed'(OP_W'(gate_ff));
         end
         ST_P: begin
            mul_cmd.a = OP_W'(req_ff.gain_p);
            mul_cmd.b = OP_W'(req_ff.err_long);
         end
         ST_D1: begin
            mul_cmd.a = OP_W'(req_ff.gain_d);
            mul_cmd.b = diff;
         end
         ST_D2: begin
            mul_cmd.a = OP_W'(tmp_ff);
            mul_cmd.b = signed'(OP_W'(cfg.inverse_period));
         end
         default: begin
            mul_cmd.a = '0;
            mul_cmd.b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      zone_in = zone_ff;
      gate_in = gate_ff;
      tmp_in = tmp_ff;
      p_in = p_ff;
      d_in = d_ff;
      int_in = int_ff;
      prev_in = prev_ff;
      started_in = started_ff;
      sat_in = sat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               sat_in = 1'b0;
               state_in = ST_ZONE;
            end
         end
         ST_ZONE: state_in = ST_ZONE_W;
         ST_ZONE_W: begin
            priority if (abs_v >= ONE_Q) begin
               zone_in = ZONE_HI_Q;
            end else if (abs_v >= HALF_Q) begin
               zone_in = ZONE_LO_Q + OP_W'(mul_res.raw >> (FRAC_W - 1));
            end else begin
               zone_in = ZONE_LO_Q;
            end
            state_in = ST_GATE;
         end
         ST_GATE: state_in = ST_GATE_W;
         ST_GATE_W: begin
            priority if (abs_e <= zone_ff) begin
               gate_in = GATE_ONE;
            end else if (gap <= ZONE_LO_Q) begin
               gate_in = GATE_ONE - GATE_W'(mul_res.raw >> RECIP_SHIFT);
            end else begin
               gate_in = '0;
            end
            state_in = ST_KIE;
         end
         ST_KIE: state_in = ST_KIE_W;
         ST_KIE_W: begin
            tmp_in = mul_res.qval;
            sat_in = sat_ff | mul_res.clip;
            state_in = ST_TERR;
         end
         ST_TERR: state_in = ST_TERR_W;
         ST_TERR_W: begin
            tmp_in = mul_res.qval;
            sat_in = sat_ff | mul_res.clip;
            state_in = ST_ACC;
         end
         ST_ACC: state_in = ST_ACC_W;
         ST_ACC_W: begin
            tmp_in = int_clamp.value;
            sat_in = sat_ff | mul_res.clip | int_clamp.clip;
            state_in = ST_INT;
         end
         ST_INT: state_in = ST_INT_W;
         ST_INT_W: begin
            int_in = mul_res.qval;
            sat_in = sat_ff | mul_res.clip;
            state_in = ST_P;
         end
         ST_P: state_in = ST_P_W;
         ST_P_W: begin
            p_in = mul_res.qval;
            sat_in = sat_ff | mul_res.clip;
            state_in = ST_D1;
         end
         ST_D1: state_in = ST_D1_W;
         ST_D1_W: begin
            tmp_in = mul_res.qval;
            sat_in = sat_ff | mul_res.clip;
            state_in = ST_D2;
         end
         ST_D2: state_in = ST_D2_W;
         ST_D2_W: begin
            d_in = mul_res.qval;
            sat_in = sat_ff | mul_res.clip;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_in.speed_cmd = cmd_clamp.value;
               rsp_in.saturated = sat_ff | cmd_clamp.clip;
               rsp_valid_in = 1'b1;
               prev_in = req_ff.err_long;
               started_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         int_ff <= '0;
         prev_ff <= '0;
         started_ff <= 1'b0;
         sat_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         int_ff <= int_in;
         prev_ff <= prev_in;
         started_ff <= started_in;
         sat_ff <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      zone_ff <= zone_in;
      gate_ff <= gate_in;
      tmp_ff <= tmp_in;
      p_ff <= p_in;
      d_ff <= d_in;
   end

endmodule

`default_nettype wire
